### hdl/sfr_pkg.sv
`timescale 1ns / 1ps

package sfr_pkg;

    // Default size limit of one frame, in bytes.
    localparam int DEF_MAX_FRAME = 300;

    localparam logic [7:0] SYNC0 = 8'h5A;
    localparam logic [7:0] SYNC1 = 8'hA5;
    localparam logic [7:0] SYNC2 = 8'hFE;
    localparam int SYNC_LEN = 3;

    // Parser phases
    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_CHIP = 3'd1;
    localparam logic [2:0] PH_LEN  = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_CHK  = 3'd4;

    // Event codes
    localparam logic [2:0] EV_NONE  = 3'd0;
    localparam logic [2:0] EV_CMD   = 3'd1;
    localparam logic [2:0] EV_DUMP  = 3'd2;
    localparam logic [2:0] EV_UNDSP = 3'd3;
    localparam logic [2:0] EV_FAIL  = 3'd4;
    localparam logic [2:0] EV_DROP  = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_PLAIN   = 2'd0;
    localparam logic [1:0] CFG_CHECKED = 2'd1;
    localparam logic [1:0] CFG_MODE    = 2'd2;

    // Dispatch modes
    localparam logic [1:0] MODE_CMD  = 2'd0;
    localparam logic [1:0] MODE_DUMP = 2'd1;

    typedef struct packed {
        logic [7:0]  byte_echo;
        logic [8:0]  frame_pos;
        logic [2:0]  event_res;
        logic [7:0]  chip_kind;
        logic [15:0] frame_length;
    } result_t;

endpackage

### hdl/serial_frame_receiver.sv
`timescale 1ns / 1ps

// Byte-serial receiver for frames of the form 5A A5 FE, chip byte, 16-bit
// little-endian length, data, and an optional XOR checksum byte. It takes one
// byte per clock cycle while in_stall is low and returns one registered result
// per byte (the byte, its position in the frame, an event code and the chip
// and length fields seen so far). The whole parser state update is
// combinational, so the sustained rate is one byte per cycle while in_stall
// is low; a two-entry output stage keeps the input open while one result
// waits on a stalled output. Frames longer than MAX_FRAME bytes are dropped.
// Write the configuration registers only while no byte is in flight.
module serial_frame_receiver #(
    parameter int MAX_FRAME = sfr_pkg::DEF_MAX_FRAME
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  byte_echo,
    output logic [8:0]  frame_pos,
    output logic [2:0]  event_res,
    output logic [7:0]  chip_kind,
    output logic [15:0] frame_length
);

    localparam int POS_W = $clog2(MAX_FRAME + 1);
    localparam int EXT_W = (POS_W > 9) ? POS_W : 9;
    localparam logic [POS_W-1:0] POS_MAX  = POS_W'(MAX_FRAME);
    localparam logic [POS_W-1:0] POS_SYNC = POS_W'(sfr_pkg::SYNC_LEN);
    localparam logic [POS_W-1:0] POS_LEN0 = POS_W'(sfr_pkg::SYNC_LEN + 1);
    localparam logic [16:0] LEN_OFS = 17'(sfr_pkg::SYNC_LEN + 2);
    localparam logic [15:0] LEN_MAX = 16'(MAX_FRAME);

    // Configuration
    logic [7:0] plain_code_reg;
    logic [7:0] checked_code_reg;
    logic [1:0] mode_reg;

    // Parser state
    logic [2:0]       phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       chip_reg, chip_next;
    logic [15:0]      len_reg, len_next;
    logic [7:0]       xor_reg, xor_next;

    // Output stage: main register and skid entry
    sfr_pkg::result_t out_reg, out_next;
    sfr_pkg::result_t skid_reg, skid_next;
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;

    sfr_pkg::result_t res;
    logic             in_fire;
    logic             out_fire;
    logic [2:0]       ev;
    logic [2:0]       disp_ev;
    logic [7:0]       sync_byte;
    logic [POS_W-1:0] pos_inc;
    logic [EXT_W-1:0] pos_ext;
    logic             at_end;
    logic             done;

    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid & ~skid_valid_reg;
    assign out_fire = out_valid_reg & ~out_stall;

    assign pos_inc = pos_reg + POS_W'(1);
    assign pos_ext = EXT_W'(pos_reg);
    assign at_end  = (17'(pos_reg) == ({1'b0, len_reg} + LEN_OFS));

    always_comb
    begin
        case (pos_reg)
            POS_W'(0): sync_byte = sfr_pkg::SYNC0;
            POS_W'(1): sync_byte = sfr_pkg::SYNC1;
            default:   sync_byte = sfr_pkg::SYNC2;
        endcase
    end

    always_comb
    begin
        case (mode_reg)
            sfr_pkg::MODE_CMD:  disp_ev = sfr_pkg::EV_CMD;
            sfr_pkg::MODE_DUMP: disp_ev = sfr_pkg::EV_DUMP;
            default:            disp_ev = sfr_pkg::EV_UNDSP;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        chip_next  = chip_reg;
        len_next   = len_reg;
        xor_next   = xor_reg;
        ev         = sfr_pkg::EV_NONE;
        done       = 1'b0;

        case (phase_reg)
            sfr_pkg::PH_HUNT:
            begin
                if (pos_reg < POS_SYNC && rx_byte == sync_byte)
                begin
                    xor_next = xor_reg ^ rx_byte;
                    pos_next = pos_inc;
                    if (pos_inc == POS_SYNC)
                    begin
                        phase_next = sfr_pkg::PH_CHIP;
                    end
                end
                else
                begin
                    phase_next = sfr_pkg::PH_HUNT;
                    pos_next   = '0;
                    xor_next   = '0;
                end
            end
            sfr_pkg::PH_CHIP:
            begin
                chip_next  = rx_byte;
                xor_next   = xor_reg ^ rx_byte;
                pos_next   = pos_inc;
                phase_next = sfr_pkg::PH_LEN;
            end
            sfr_pkg::PH_LEN:
            begin
                xor_next = xor_reg ^ rx_byte;
                if (pos_reg == POS_LEN0)
                begin
                    len_next = {8'h00, rx_byte};
                end
                else
                begin
                    len_next   = {rx_byte, len_reg[7:0]};
                    phase_next = sfr_pkg::PH_DATA;
                end
                pos_next = pos_inc;
                if (pos_inc >= POS_MAX)
                begin
                    phase_next = sfr_pkg::PH_HUNT;
                    pos_next   = '0;
                    xor_next   = '0;
                    ev         = sfr_pkg::EV_DROP;
                end
            end
            sfr_pkg::PH_DATA:
            begin
                if (len_reg == 16'h0000 || len_reg > LEN_MAX)
                begin
                    phase_next = sfr_pkg::PH_HUNT;
                    pos_next   = '0;
                    xor_next   = '0;
                    ev         = sfr_pkg::EV_DROP;
                end
                else
                begin
                    // The plain chip code wins when both codes are equal.
                    if (at_end && chip_reg == plain_code_reg)
                    begin
                        ev   = disp_ev;
                        done = 1'b1;
                    end
                    else if (at_end && chip_reg == checked_code_reg)
                    begin
                        phase_next = sfr_pkg::PH_CHK;
                    end

                    if (done)
                    begin
                        phase_next = sfr_pkg::PH_HUNT;
                        pos_next   = '0;
                        xor_next   = '0;
                    end
                    else
                    begin
                        xor_next = xor_reg ^ rx_byte;
                        pos_next = pos_inc;
                        if (pos_inc >= POS_MAX)
                        begin
                            phase_next = sfr_pkg::PH_HUNT;
                            pos_next   = '0;
                            xor_next   = '0;
                            ev         = sfr_pkg::EV_DROP;
                        end
                    end
                end
            end
            sfr_pkg::PH_CHK:
            begin
                ev         = (xor_reg == rx_byte) ? disp_ev : sfr_pkg::EV_FAIL;
                phase_next = sfr_pkg::PH_HUNT;
                pos_next   = '0;
                xor_next   = '0;
            end
            default:
            begin
                phase_next = sfr_pkg::PH_HUNT;
                pos_next   = '0;
                xor_next   = '0;
            end
        endcase
    end

    always_comb
    begin
        res.byte_echo    = rx_byte;
        res.frame_pos    = pos_ext[8:0];
        res.event_res    = ev;
        res.chip_kind    = chip_next;
        res.frame_length = len_next;
    end

    // A new result goes to the output register when it is free or draining,
    // otherwise to the skid entry.
    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;

        if (out_fire || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = res;
                out_valid_next = in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plain_code_reg   <= 8'd0;
            checked_code_reg <= 8'd1;
            mode_reg         <= sfr_pkg::MODE_CMD;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                sfr_pkg::CFG_PLAIN:   plain_code_reg   <= cfg_wdata;
                sfr_pkg::CFG_CHECKED: checked_code_reg <= cfg_wdata;
                sfr_pkg::CFG_MODE:    mode_reg         <= cfg_wdata[1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sfr_pkg::PH_HUNT;
            pos_reg   <= '0;
            chip_reg  <= 8'd0;
            len_reg   <= 16'd0;
            xor_reg   <= 8'd0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            chip_reg  <= chip_next;
            len_reg   <= len_next;
            xor_reg   <= xor_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid    = out_valid_reg;
    assign byte_echo    = out_reg.byte_echo;
    assign frame_pos    = out_reg.frame_pos;
    assign event_res    = out_reg.event_res;
    assign chip_kind    = out_reg.chip_kind;
    assign frame_length = out_reg.frame_length;

endmodule
